// File: rtl/core/bpd_pkg.sv
// Package for the Bayer pixel decompressor: prefix code table, code decode
// function, register map and reset values. No dependencies.
package bpd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W      = 11;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  localparam logic [7:0] MASK_3 = 8'hE0;
  localparam logic [7:0] MASK_4 = 8'hF0;
  localparam logic [7:0] MASK_5 = 8'hF8;
  localparam logic [7:0] MASK_6 = 8'hFC;
  localparam logic [7:0] MASK_ABS = 8'h0F;
  localparam logic [7:0] CODE_PLUS4   = 8'h80;
  localparam logic [7:0] CODE_MINUS4  = 8'hA0;
  localparam logic [7:0] CODE_PLUS11  = 8'hD0;
  localparam logic [7:0] CODE_MINUS11 = 8'hF0;
  localparam logic [7:0] CODE_PLUS20  = 8'hC8;
  localparam logic [7:0] CODE_MINUS20 = 8'hC0;
  localparam logic [7:0] CODE_UNKNOWN = 8'hC4;

  localparam logic signed [5:0] DELTA_SMALL = 6'sd4;
  localparam logic signed [5:0] DELTA_MID   = 6'sd11;
  localparam logic signed [5:0] DELTA_LARGE = 6'sd20;

  localparam logic [3:0] RAW_LEN = 4'd8;

  typedef struct packed {
    logic [3:0]        len;
    logic signed [5:0] delta;
    logic              absv;
    logic              unk;
  } code_info_t;

  function automatic code_info_t decode_code(input logic [7:0] c);
    code_info_t r;
    r.len   = 4'd1;
    r.delta = '0;
    r.absv  = 1'b0;
    r.unk   = 1'b0;
    if (!c[7]) begin
      r.len = 4'd1;
    end else if ((c & MASK_3) == CODE_PLUS4) begin
      r.len = 4'd3;
      r.delta = DELTA_SMALL;
    end else if ((c & MASK_3) == CODE_MINUS4) begin
      r.len = 4'd3;
      r.delta = -DELTA_SMALL;
    end else if ((c & MASK_4) == CODE_PLUS11) begin
      r.len = 4'd4;
      r.delta = DELTA_MID;
    end else if ((c & MASK_4) == CODE_MINUS11) begin
      r.len = 4'd4;
      r.delta = -DELTA_MID;
    end else if ((c & MASK_5) == CODE_PLUS20) begin
      r.len = 4'd5;
      r.delta = DELTA_LARGE;
    end else if ((c & MASK_6) == CODE_MINUS20) begin
      r.len = 4'd6;
      r.delta = -DELTA_LARGE;
    end else if ((c & MASK_6) == CODE_UNKNOWN) begin
      r.len = 4'd8;
      r.unk = 1'b1;
    end else begin
      r.len = 4'd8;
      r.absv = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bpd_if.sv
// Stream interfaces for the Bayer pixel decompressor: compressed byte input
// and decoded pixel output. Both use a valid/ready handshake. No dependencies.
interface bpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface bpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       unknown_code;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output pixel_value, output unknown_code,
                  output frame_end, output last_of_run, input ready);
  modport sink (input valid, input pixel_value, input unknown_code,
                input frame_end, input last_of_run, output ready);
endinterface

// File: rtl/core/bpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bayer_pixel_decompressor.sv
// Decodes a compressed raw Bayer stream, one byte per input beat, MSB first,
// into 8-bit pixels in raster order, one pixel per output beat. After a byte is
// accepted the block yields one pixel per clock while the output is taken; a
// byte completes up to eight pixels, and no new byte is taken until it is done.
// The two-row line memory is read once for the pixel above and written once
// per pixel. The line memory needs no clearing after reset. Uses bpd_pkg,
// bpd_if and bpd_ram.
module bayer_pixel_decompressor
  import bpd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  bpd_in_if.sink               code_in,
  bpd_out_if.source            pixel_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(2 * MAX_WIDTH);
  localparam int WB = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HB = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [14:0]   bit_buffer;
  logic [3:0]    bits_held;
  logic [RW-1:0] row_count;
  logic [CW-1:0] column_count;
  logic          busy;
  logic [2:0]    run_count;
  logic [7:0]    prev1;
  logic [7:0]    prev2;

  logic       out_valid;
  logic [7:0] out_pixel;
  logic       out_unknown;
  logic       out_end;
  logic       out_last;

  logic [WB-1:0] used_w;
  logic [HB-1:0] used_h;
  logic [WB-1:0] fw_ext;
  logic [HB-1:0] fh_ext;

  logic          cfg_write;
  logic          in_fire;
  logic          out_free;
  logic          step_fire;
  logic          step_stop;

  logic [22:0]   win_shift;
  logic [7:0]    window;
  logic          raw_pos;
  code_info_t    code;
  logic [3:0]    len;
  logic          complete;

  logic [7:0]    top;
  logic [8:0]    pair_sum;
  logic [7:0]    pred;
  logic signed [9:0] pred_delta;
  logic [7:0]    pix;

  logic          col_end;
  logic          row_end;
  logic          frame_done;
  logic [CW-1:0] column_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_adv;
  logic [RW-1:0] row_adv;

  logic [3:0]    held_after;
  logic [22:0]   win_shift_n;
  logic [7:0]    window_n;
  logic          raw_n;
  code_info_t    code_n;
  logic [3:0]    len_n;
  logic          run_last;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(PDATA_W-CFG_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(PDATA_W-CFG_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    fw_ext = WB'(frame_width);
    fh_ext = HB'(frame_height);
    if (fw_ext < WB'(MIN_WIDTH)) begin
      used_w = WB'(MIN_WIDTH);
    end else if (fw_ext > WB'(MAX_WIDTH)) begin
      used_w = WB'(MAX_WIDTH);
    end else begin
      used_w = fw_ext;
    end
    if (fh_ext < HB'(MIN_HEIGHT)) begin
      used_h = HB'(MIN_HEIGHT);
    end else if (fh_ext > HB'(MAX_HEIGHT)) begin
      used_h = HB'(MAX_HEIGHT);
    end else begin
      used_h = fh_ext;
    end
  end

  // Current code.
  assign in_fire   = code_in.valid && code_in.ready;
  assign code_in.ready = !busy;
  assign out_free  = !out_valid || pixel_out.ready;

  assign win_shift = {bit_buffer, 8'h00} >> bits_held;
  assign window    = win_shift[7:0];
  assign raw_pos   = ((row_count >> 1) == '0) && ((column_count >> 1) == '0);
  assign code      = decode_code(window);
  assign len       = raw_pos ? RAW_LEN : code.len;
  assign complete  = len <= bits_held;
  assign step_fire = busy && complete && out_free;
  assign step_stop = busy && !complete;

  // Pixel value.
  assign pair_sum = {1'b0, top} + {1'b0, prev2};

  always_comb begin
    if ((column_count >> 1) == '0) begin
      pred = top;
    end else if ((row_count >> 1) == '0) begin
      pred = prev2;
    end else begin
      pred = pair_sum[8:1];
    end
    pred_delta = $signed({2'b00, pred}) + {{4{code.delta[5]}}, code.delta};
    if (raw_pos) begin
      pix = window;
    end else if (code.absv) begin
      pix = {window[3:0] & MASK_ABS[3:0], 4'h0};
    end else if (pred_delta[9]) begin
      pix = 8'h00;
    end else if (pred_delta[8]) begin
      pix = 8'hFF;
    end else begin
      pix = pred_delta[7:0];
    end
  end

  // Raster position.
  assign col_end    = (WB'(column_count) + WB'(1)) >= used_w;
  assign row_end    = (HB'(row_count) + HB'(1)) >= used_h;
  assign frame_done = col_end && row_end;

  always_comb begin
    col_adv = column_count;
    row_adv = row_count;
    if (col_end) begin
      col_adv = '0;
      row_adv = row_end ? '0 : row_count + RW'(1);
    end else begin
      col_adv = column_count + CW'(1);
    end
    column_next = step_fire ? col_adv : column_count;
    row_next    = step_fire ? row_adv : row_count;
  end

  // Look ahead at the following code to mark the last pixel of a byte.
  assign held_after  = bits_held - len;
  assign win_shift_n = {bit_buffer, 8'h00} >> held_after;
  assign window_n    = win_shift_n[7:0];
  assign raw_n       = ((row_adv >> 1) == '0) && ((col_adv >> 1) == '0);
  assign code_n      = decode_code(window_n);
  assign len_n       = raw_n ? RAW_LEN : code_n.len;
  assign run_last    = frame_done || (run_count == 3'd7) || (len_n > held_after);

  // Line memory: the read address always tracks the position of the next
  // cycle, so the pixel above is ready when that position is decoded.
  assign waddr = row_count[0] ? AW'(MAX_WIDTH) + AW'(column_count) : AW'(column_count);
  assign raddr = row_next[0] ? AW'(MAX_WIDTH) + AW'(column_next) : AW'(column_next);

  bpd_ram #(
    .WIDTH (8),
    .DEPTH (2 * MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (step_fire),
    .waddr (waddr),
    .wdata (pix),
    .raddr (raddr),
    .rdata (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer   <= '0;
      bits_held    <= '0;
      row_count    <= '0;
      column_count <= '0;
      busy         <= 1'b0;
      run_count    <= '0;
    end else begin
      row_count    <= row_next;
      column_count <= column_next;
      if (in_fire) begin
        bit_buffer <= {bit_buffer[6:0], code_in.code_byte};
        bits_held  <= bits_held + 4'd8;
        busy       <= 1'b1;
        run_count  <= '0;
      end else if (step_fire) begin
        bits_held <= frame_done ? 4'd0 : held_after;
        busy      <= !run_last;
        run_count <= run_count + 3'd1;
      end else if (step_stop) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      prev2 <= prev1;
      prev1 <= pix;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_pixel   <= pix;
      out_unknown <= !raw_pos && code.unk;
      out_end     <= frame_done;
      out_last    <= run_last;
    end
  end

  assign pixel_out.valid        = out_valid;
  assign pixel_out.pixel_value  = out_pixel;
  assign pixel_out.unknown_code = out_unknown;
  assign pixel_out.frame_end    = out_end;
  assign pixel_out.last_of_run  = out_last;

endmodule
